FILE: hw/rtl/slfr_pkg.sv
`timescale 1ns / 1ps

package slfr_pkg;

	// end-of-frame status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_END_ERR   = 2'd1,
		ST_CHECK_ERR = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// result item kinds
	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_REPORT  = 1'b1
	} kind_t;

	// register indexes
	localparam logic CFG_START_BYTE = 1'b0;
	localparam logic CFG_END_BYTE   = 1'b1;

	// register reset values
	localparam logic [7:0] START_BYTE_RST = 8'hFA;
	localparam logic [7:0] END_BYTE_RST   = 8'hF5;

	// frame layout
	localparam logic [7:0] CHECK_MASK     = 8'h7F;
	localparam int         HEADER_BYTES   = 3;
	localparam int         FRAME_OVERHEAD = 5;

endpackage

FILE: hw/rtl/stx_length_frame_receiver.sv
`timescale 1ns / 1ps

// channel   | handshake           | payload
// ----------+---------------------+-----------------------------------------------
// input     | in_valid / in_ready | rx_byte
// result    | out_valid/out_ready | result_kind, payload_byte, frame_type,
//           |                     | frame_length, frame_status
// config    | cfg_we              | cfg_index, cfg_wdata
//
// One byte per cycle unless a result is held up: a byte is caught in an input
// register, and from there the frame state update plus result formation
// write the result register.
// Reset puts the receiver in hunt mode with the default start and end bytes.
// A waiting result stalls the input register only when the next byte also
// produces a result; bytes with no result keep flowing.

module stx_length_frame_receiver #(
	parameter int FRAME_LIMIT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] payload_byte,
	output logic [7:0] frame_type,
	output logic [7:0] frame_length,
	output logic [1:0] frame_status,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata
);
	import slfr_pkg::*;

	localparam int PW = $clog2(FRAME_LIMIT + 1);
	localparam int CW = (PW > 9) ? PW : 9;

	// configuration registers
	logic [7:0] start_byte_q, end_byte_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame state
	logic          in_frame_q;
	logic [PW-1:0] pos_q;
	logic [7:0]    type_q, len_q, xor_q, chk_q;

	// next state and result
	logic          in_frame_d;
	logic [PW-1:0] pos_d;
	logic [7:0]    type_d, len_d, xor_d, chk_d;
	logic [CW-1:0] p, len_ext, lim3;
	logic          has_res;
	kind_t         res_kind;
	status_t       res_status;
	logic [7:0]    res_byte;
	logic          adv_s1;

	// output register
	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] pbyte_q, ftype_q, flen_q;
	status_t    status_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			end_byte_q   <= END_BYTE_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_START_BYTE) begin
				start_byte_q <= cfg_wdata;
			end else if (cfg_index == CFG_END_BYTE) begin
				end_byte_q <= cfg_wdata;
			end
		end
	end

	// stage advances unless a result meets a full, stalled output register
	assign adv_s1   = valid_s1 && (!has_res || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byte_s1  <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				byte_s1 <= rx_byte;
			end
		end
	end

	// frame state update for the byte in the input register
	always_comb begin
		in_frame_d = in_frame_q;
		pos_d      = pos_q;
		type_d     = type_q;
		len_d      = len_q;
		xor_d      = xor_q;
		chk_d      = chk_q;
		has_res    = 1'b0;
		res_kind   = KIND_PAYLOAD;
		res_status = ST_OK;
		res_byte   = '0;
		p          = CW'(pos_q) + CW'(1);
		len_ext    = '0;
		lim3       = '0;
		if (!in_frame_q) begin
			// hunting for the start byte
			if (byte_s1 == start_byte_q) begin
				in_frame_d = 1'b1;
				pos_d      = PW'(1);
				type_d     = '0;
				len_d      = '0;
				xor_d      = byte_s1;
				chk_d      = '0;
			end
		end else begin
			if (p == CW'(2)) begin
				type_d = byte_s1;
			end
			if (p == CW'(HEADER_BYTES)) begin
				len_d = byte_s1;
			end
			len_ext = CW'(len_d);
			lim3    = len_ext + CW'(HEADER_BYTES);
			if (p <= lim3) begin
				xor_d = xor_q ^ byte_s1;
			end else if (p == lim3 + CW'(1)) begin
				chk_d = byte_s1;
			end
			pos_d = PW'(p);
			if (p > CW'(HEADER_BYTES) && p >= len_ext + CW'(FRAME_OVERHEAD)) begin
				// last byte of the frame
				has_res  = 1'b1;
				res_kind = KIND_REPORT;
				if (byte_s1 != end_byte_q) begin
					res_status = ST_END_ERR;
				end else if ((xor_d & CHECK_MASK) != chk_d) begin
					res_status = ST_CHECK_ERR;
				end
			end else if (p >= CW'(FRAME_LIMIT)) begin
				// frame too long: drop byte and report
				has_res    = 1'b1;
				res_kind   = KIND_REPORT;
				res_status = ST_OVERFLOW;
			end else if (p > CW'(HEADER_BYTES) && p <= lim3) begin
				has_res  = 1'b1;
				res_byte = byte_s1;
			end
			if (res_kind == KIND_REPORT) begin
				in_frame_d = 1'b0;
				pos_d      = '0;
			end
		end
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			type_q     <= '0;
			len_q      <= '0;
			xor_q      <= '0;
			chk_q      <= '0;
		end else if (adv_s1) begin
			in_frame_q <= in_frame_d;
			pos_q      <= pos_d;
			type_q     <= in_frame_d ? type_d : 8'h00;
			len_q      <= in_frame_d ? len_d : 8'h00;
			xor_q      <= in_frame_d ? xor_d : 8'h00;
			chk_q      <= in_frame_d ? chk_d : 8'h00;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_res) begin
			kind_q   <= res_kind;
			pbyte_q  <= res_byte;
			ftype_q  <= type_d;
			flen_q   <= len_d;
			status_q <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign payload_byte = pbyte_q;
	assign frame_type   = ftype_q;
	assign frame_length = flen_q;
	assign frame_status = status_q;

	// checks
	a_hunt_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> pos_q == '0)
		else $error("position not cleared while hunting");

	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (CW'(pos_q) < CW'(FRAME_LIMIT)))
		else $error("frame position reached the limit");

	a_report_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && has_res && res_kind == KIND_REPORT) |=> !in_frame_q)
		else $error("end report did not return to hunting");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

endmodule

FILE: dv/tb_stx_length_frame_receiver.sv
`timescale 1ns / 1ps

module tb_stx_length_frame_receiver;
	import slfr_pkg::*;

	localparam int FRAME_LIMIT    = 256;
	localparam int STAGES         = 6;
	localparam int STAGE_ITEMS    = 225;
	localparam int SETTLE_CYCLES  = 8;
	localparam int QUIET_LIMIT    = 4000;
	localparam int MAX_REPORTED   = 100;

	typedef logic [7:0] byte_q_t[$];

	typedef enum int {
		FAULT_NONE,
		FAULT_END,
		FAULT_CHECK,
		FAULT_BOTH
	} fault_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] ftype;
		logic [7:0] flen;
		status_t    status;
	} frame_output_t;

	// mirror of the frame receiver plus the outputs it still owes
	class frame_tracker;
		int            limit;
		logic [7:0]    start_val;
		logic [7:0]    end_val;
		bit            in_frame;
		int            position;
		logic [7:0]    msg_type;
		logic [7:0]    len_held;
		logic [7:0]    xor_acc;
		logic [7:0]    check_rx;
		frame_output_t due_outputs[$];
		int            errors;

		function new(int frame_limit);
			limit     = frame_limit;
			start_val = START_BYTE_RST;
			end_val   = END_BYTE_RST;
			errors    = 0;
			hunt();
		endfunction

		function void hunt();
			in_frame = 1'b0;
			position = 0;
			msg_type = 8'h00;
			len_held = 8'h00;
			xor_acc  = 8'h00;
			check_rx = 8'h00;
		endfunction

		function void set_reg(logic idx, logic [7:0] value);
			if (idx == CFG_START_BYTE) begin
				start_val = value;
			end else begin
				end_val = value;
			end
		endfunction

		function void owe(kind_t kind, logic [7:0] data, status_t status);
			frame_output_t o;
			o.kind   = kind;
			o.data   = data;
			o.ftype  = msg_type;
			o.flen   = len_held;
			o.status = status;
			due_outputs.push_back(o);
		endfunction

		// advance the frame state by one accepted byte
		function void take_byte(logic [7:0] b);
			int      p;
			int      payload_end;
			bit      is_payload;
			status_t st;
			if (!in_frame) begin
				if (b == start_val) begin
					hunt();
					in_frame = 1'b1;
					position = 1;
					xor_acc  = b;
				end
				return;
			end
			p        = position + 1;
			position = p;
			if (p == 2) begin
				msg_type = b;
			end else if (p == HEADER_BYTES) begin
				len_held = b;
			end
			payload_end = int'(len_held) + HEADER_BYTES;
			is_payload  = (p > HEADER_BYTES) && (p <= payload_end);
			if (p <= payload_end) begin
				xor_acc = xor_acc ^ b;
			end else if (p == payload_end + 1) begin
				check_rx = b;
			end
			// frame complete: end byte checked before checksum
			if (p > HEADER_BYTES && p >= int'(len_held) + FRAME_OVERHEAD) begin
				if (b != end_val) begin
					st = ST_END_ERR;
				end else if ((xor_acc & CHECK_MASK) != check_rx) begin
					st = ST_CHECK_ERR;
				end else begin
					st = ST_OK;
				end
				owe(KIND_REPORT, 8'h00, st);
				hunt();
				return;
			end
			// frame too long: byte dropped, back to hunting
			if (p >= limit) begin
				owe(KIND_REPORT, 8'h00, ST_OVERFLOW);
				hunt();
				return;
			end
			if (is_payload) begin
				owe(KIND_PAYLOAD, b, ST_OK);
			end
		endfunction

		task report(string msg);
			if (errors < MAX_REPORTED) begin
				$display("%0t mismatch: %s", $realtime, msg);
			end
			errors++;
		endtask

		task match_output(kind_t kind, logic [7:0] data, logic [7:0] ftype,
				logic [7:0] flen, status_t status);
			frame_output_t o;
			if (due_outputs.size() == 0) begin
				report($sformatf("unexpected result kind=%0d data=%02h type=%02h len=%0d st=%0d",
					kind, data, ftype, flen, status));
				return;
			end
			o = due_outputs.pop_front();
			if (kind !== o.kind) begin
				report($sformatf("result_kind %0d, want %0d", kind, o.kind));
			end
			if (data !== o.data) begin
				report($sformatf("payload_byte %02h, want %02h", data, o.data));
			end
			if (ftype !== o.ftype) begin
				report($sformatf("frame_type %02h, want %02h", ftype, o.ftype));
			end
			if (flen !== o.flen) begin
				report($sformatf("frame_length %0d, want %0d", flen, o.flen));
			end
			if (status !== o.status) begin
				report($sformatf("frame_status %0d, want %0d", status, o.status));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte      = 8'h00;
	logic       out_valid;
	logic       out_ready    = 1'b0;
	logic       result_kind;
	logic [7:0] payload_byte;
	logic [7:0] frame_type;
	logic [7:0] frame_length;
	logic [1:0] frame_status;
	logic       cfg_we       = 1'b0;
	logic       cfg_index    = CFG_START_BYTE;
	logic [7:0] cfg_wdata    = 8'h00;

	frame_tracker tracker;
	int           send_idle  = 0;
	int           recv_idle  = 0;
	int           quiet      = 0;
	int           stage_items;
	logic [7:0]   cur_start  = START_BYTE_RST;
	logic [7:0]   cur_end    = END_BYTE_RST;

	stx_length_frame_receiver #(
		.FRAME_LIMIT(FRAME_LIMIT)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.payload_byte(payload_byte),
		.frame_type  (frame_type),
		.frame_length(frame_length),
		.frame_status(frame_status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: check accepted items, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			tracker.match_output(kind_t'(result_kind), payload_byte, frame_type,
				frame_length, status_t'(frame_status));
		end
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet = 0;
		end else begin
			quiet = quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		tracker.take_byte(b);
	endtask

	// a byte that cannot open a frame
	task automatic send_noise();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == cur_start) begin
			b = b ^ 8'h01;
		end
		send_byte(b);
	endtask

	function automatic byte_q_t random_bytes(int n);
		byte_q_t q;
		repeat (n) q.push_back(8'($urandom_range(255)));
		return q;
	endfunction

	// whole frame, cut at the buffer limit when it would overflow
	task automatic send_frame(input logic [7:0] ftype, input byte_q_t data,
			input fault_t fault);
		byte_q_t    frame;
		logic [7:0] acc;
		logic [7:0] chk;
		logic [7:0] tail;
		int         count;
		frame = {cur_start, ftype, 8'(data.size())};
		acc   = cur_start ^ ftype ^ 8'(data.size());
		foreach (data[i]) begin
			frame.push_back(data[i]);
			acc = acc ^ data[i];
		end
		chk  = acc & CHECK_MASK;
		tail = cur_end;
		if (fault == FAULT_CHECK || fault == FAULT_BOTH) begin
			chk = chk ^ (8'h01 << $urandom_range(7));
		end
		if (fault == FAULT_END || fault == FAULT_BOTH) begin
			tail = tail ^ 8'($urandom_range(1, 255));
		end
		frame.push_back(chk);
		frame.push_back(tail);
		count = (frame.size() > FRAME_LIMIT) ? FRAME_LIMIT : frame.size();
		for (int i = 0; i < count; i++) begin
			send_byte(frame[i]);
		end
		stage_items += count;
	endtask

	// hold the sender until every owed result is out, then let the pipe empty
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (tracker.due_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [7:0] sb, input logic [7:0] eb);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_BYTE;
		cfg_wdata <= sb;
		@(posedge clk);
		tracker.set_reg(CFG_START_BYTE, sb);
		cfg_index <= CFG_END_BYTE;
		cfg_wdata <= eb;
		@(posedge clk);
		tracker.set_reg(CFG_END_BYTE, eb);
		cfg_we    <= 1'b0;
		cur_start = sb;
		cur_end   = eb;
		@(posedge clk);
	endtask

	initial begin
		byte_q_t    q;
		int         r;
		int         flen;
		fault_t     fault;
		logic [7:0] starts[STAGES];
		logic [7:0] ends[STAGES];

		tracker = new(FRAME_LIMIT);
		starts = '{START_BYTE_RST, 8'h00, 8'hFF, 8'($urandom_range(255)), 8'h7E,
			8'($urandom_range(255))};
		ends   = '{END_BYTE_RST, 8'hFF, 8'h00, 8'($urandom_range(255)), 8'h7E,
			8'($urandom_range(255))};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int stage = 0; stage < STAGES; stage++) begin
			if (stage < 2) begin
				send_idle = 15;
				recv_idle = 69;
			end else if (stage < 4) begin
				send_idle = 69;
				recv_idle = 15;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_config(starts[stage], ends[stage]);
			stage_items = 0;

			if (stage == 0) begin
				// hunting noise, extremes, each status, start byte inside a frame
				send_byte(8'h00);
				send_byte(8'hFF);
				send_frame(8'h00, random_bytes(0), FAULT_NONE);
				q = {cur_start};
				send_frame(8'hFF, q, FAULT_NONE);
				q = {8'h00, 8'hFF};
				send_frame(8'h5A, q, FAULT_END);
				send_frame(8'hA5, random_bytes(1), FAULT_CHECK);
				send_frame(8'h3C, random_bytes(0), FAULT_BOTH);
				// frame ending exactly at the buffer limit, then a longer one that runs past it
				send_frame(8'h81, random_bytes(FRAME_LIMIT - FRAME_OVERHEAD), FAULT_NONE);
				send_frame(8'h7F, random_bytes(255), FAULT_NONE);
				wait_drained();
			end

			// mostly well-formed frames, some broken ones and line noise
			while (stage_items < STAGE_ITEMS) begin
				if ($urandom_range(99) < 8) begin
					repeat ($urandom_range(1, 4)) send_noise();
				end
				r = $urandom_range(99);
				if (r < 3) begin
					flen = $urandom_range(240, 255);
				end else if (r < 20) begin
					flen = $urandom_range(9, 40);
				end else begin
					flen = $urandom_range(0, 8);
				end
				r = $urandom_range(99);
				if (r < 80) begin
					fault = FAULT_NONE;
				end else if (r < 87) begin
					fault = FAULT_END;
				end else if (r < 94) begin
					fault = FAULT_CHECK;
				end else begin
					fault = FAULT_BOTH;
				end
				send_frame(8'($urandom_range(255)), random_bytes(flen), fault);
				if ($urandom_range(99) < 3) begin
					wait_drained();
				end
			end
			wait_drained();
		end

		if (tracker.due_outputs.size() != 0) begin
			tracker.report($sformatf("%0d results never arrived",
				tracker.due_outputs.size()));
		end
		if (tracker.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
